FILE: sv/sphf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the SPH pressure force accumulator.
// No dependencies; every other file uses this package.
package sphf_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;
    localparam int ACC_W     = 96;
    localparam int OPD_W     = 64;
    localparam int CNT_W     = 7;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KSCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASS   = 3'd4;

    localparam logic [31:0] RADIUS_RST = 32'd65536;
    localparam logic [47:0] KSCALE_RST = 48'd16405566606;
    localparam logic [31:0] TARGET_RST = 32'd65536;
    localparam logic [31:0] GAIN_RST   = 32'd65536;
    localparam logic [31:0] MASS_RST   = 32'd655360;

    localparam logic [46:0] TERM_CAP   = {47{1'b1}};
    localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } alu_op_t;

    typedef struct packed {
        logic             start;
        alu_op_t          op;
        logic [OPD_W-1:0] a;
        logic [OPD_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] result;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_PRS,
        ST_SLP,
        ST_T1,
        ST_T2,
        ST_T3,
        ST_DIRX,
        ST_DIRY,
        ST_TX,
        ST_TY,
        ST_FIN
    } sphf_state_t;

endpackage

FILE: sv/sphf_if.sv
`timescale 1ns / 1ps
// Channel interfaces: particle words in, force words out, configuration writes.
// Depends on sphf_pkg for the configuration widths.
interface sphf_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_x;
    logic signed [31:0] sample_y;
    logic signed [31:0] particle_x;
    logic signed [31:0] particle_y;
    logic        [31:0] particle_density;
    logic               last_particle;
    modport source (output valid, sample_x, sample_y, particle_x, particle_y,
                    particle_density, last_particle, input ready);
    modport sink (input valid, sample_x, sample_y, particle_x, particle_y,
                  particle_density, last_particle, output ready);
endinterface

interface sphf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic        [1:0]  status;
    modport source (output valid, force_x, force_y, status, input ready);
    modport sink (input valid, force_x, force_y, status, output ready);
endinterface

interface sphf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sphf_pkg::CFG_IDX_W-1:0] index;
    logic [sphf_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/sphf_alu.sv
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply, restoring divide, digit square root.
// Depends on sphf_pkg for request and response structs.
module sphf_alu
    import sphf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    alu_op_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0] ma_reg, ma_next;
    logic [OPD_W-1:0] mb_reg, mb_next;
    logic [33:0]      rem_reg, rem_next;
    logic [31:0]      root_reg, root_next;
    logic [31:0]      dvs_reg, dvs_next;

    logic [32:0] div_tmp;
    logic        div_ge;
    logic [35:0] sq_tmp;
    logic [35:0] sq_trial;
    logic        sq_ge;

    always_comb
    begin
        div_tmp  = {rem_reg[31:0], mb_reg[OPD_W-1]};
        div_ge   = (div_tmp >= {1'b0, dvs_reg});
        sq_tmp   = {rem_reg, mb_reg[OPD_W-1:OPD_W-2]};
        sq_trial = {2'b00, root_reg, 2'b01};
        sq_ge    = (sq_tmp >= sq_trial);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        dvs_next  = dvs_reg;
        if (!busy_reg)
        begin
            if (req.start)
            begin
                busy_next = 1'b1;
                op_next   = req.op;
                acc_next  = '0;
                ma_next   = {{(ACC_W-OPD_W){1'b0}}, req.a};
                mb_next   = (req.op == OP_MUL) ? req.b : req.a;
                rem_next  = '0;
                root_next = '0;
                dvs_next  = req.b[31:0];
                cnt_next  = (req.op == OP_DIV) ? DIV_STEPS : SQRT_STEPS;
            end
        end
        else
        begin
            case (op_reg)
                OP_MUL:
                begin
                    if (mb_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        if (mb_reg[0])
                            acc_next = acc_reg + ma_reg;
                        ma_next = {ma_reg[ACC_W-2:0], 1'b0};
                        mb_next = {1'b0, mb_reg[OPD_W-1:1]};
                    end
                end
                OP_DIV:
                begin
                    if (cnt_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next = div_ge ? {2'b00, div_tmp[31:0] - dvs_reg}
                                          : {2'b00, div_tmp[31:0]};
                        mb_next  = {mb_reg[OPD_W-2:0], div_ge};
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                OP_SQRT:
                begin
                    if (cnt_reg == '0)
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        rem_next  = sq_ge ? 34'(sq_tmp - sq_trial) : sq_tmp[33:0];
                        root_next = {root_reg[30:0], sq_ge};
                        mb_next   = {mb_reg[OPD_W-3:0], 2'b00};
                        cnt_next  = cnt_reg - 1'b1;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dvs_reg  <= dvs_next;
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        case (op_reg)
            OP_MUL:  rsp.result = acc_reg;
            OP_DIV:  rsp.result = {{(ACC_W-OPD_W){1'b0}}, mb_reg};
            OP_SQRT: rsp.result = {{(ACC_W-32){1'b0}}, root_reg};
            default: rsp.result = acc_reg;
        endcase
    end

endmodule

FILE: sv/sph_pressure_force_accumulator.sv
`timescale 1ns / 1ps
// SPH pressure force accumulator top level. Depends on sphf_pkg, sphf_if, sphf_alu.
// A new particle word is taken only once the previous one is through the sequencer,
// and later still while a finished force word waits for the output register.
// The shared unit sets the pace: bit-serial multiplies (one multiplier bit per cycle,
// stopping early), 64-step divides and a 32-step square root run back to back.
// Reset (rst_n low, asynchronous) loads the register defaults, clears sums and flags.
module sph_pressure_force_accumulator
    import sphf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    sphf_in_if.sink   particle,
    sphf_out_if.source result,
    sphf_cfg_if.sink  cfg
);

    // Configuration registers
    logic [31:0] radius_reg;
    logic [47:0] kscale_reg;
    logic [31:0] target_reg;
    logic [31:0] gain_reg;
    logic [31:0] mass_reg;

    sphf_state_t state_reg, state_next;

    // Per-particle working registers
    logic [31:0] ax_reg, ax_next;
    logic [31:0] ay_reg, ay_next;
    logic        xneg_reg, xneg_next;
    logic        yneg_reg, yneg_next;
    logic [31:0] dens_reg, dens_next;
    logic        last_reg, last_next;
    logic [63:0] qx_reg, qx_next;
    logic [31:0] dist_reg, dist_next;
    logic [46:0] pmag_reg, pmag_next;
    logic        pneg_reg, pneg_next;
    logic [46:0] t_reg, t_next;
    logic        tsat_reg, tsat_next;
    logic [30:0] dirx_reg, dirx_next;
    logic [30:0] diry_reg, diry_next;
    logic [46:0] tx_reg, tx_next;

    // Running state
    logic [47:0] sum_x_reg, sum_x_next;
    logic [47:0] sum_y_reg, sum_y_next;
    logic        sat_reg, sat_next;
    logic        zden_reg, zden_next;

    // Output register
    logic        ovalid_reg, ovalid_next;
    logic [31:0] fx_reg, fx_next;
    logic [31:0] fy_reg, fy_next;
    logic [1:0]  st_reg, st_next;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic        in_fire;
    logic [32:0] dx;
    logic [32:0] dy;
    logic [32:0] ndx;
    logic [32:0] ndy;
    logic [32:0] err;
    logic [32:0] nerr;
    logic [31:0] err_mag;
    logic [31:0] gain_mag;
    logic [31:0] ngain;
    logic [64:0] sq_sum;
    logic        clip1;
    logic        clip3;
    logic [46:0] t1_val;
    logic [46:0] t3_val;
    logic [48:0] addx;
    logic [48:0] addy;
    logic        osat_x;
    logic        osat_y;

    sphf_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // Add a signed term to a 48-bit sum, clip to the 48-bit range; MSB flags a clip.
    function automatic logic [48:0] sat_add48(input logic [47:0] sum,
                                              input logic [46:0] mag,
                                              input logic neg);
        logic [48:0] term;
        logic [48:0] s;
        term = neg ? (49'd0 - {2'b00, mag}) : {2'b00, mag};
        s    = {sum[47], sum} + term;
        if (s[48] != s[47])
            return {1'b1, s[48] ? {1'b1, 47'd0} : {1'b0, TERM_CAP}};
        return {1'b0, s[47:0]};
    endfunction

    assign particle.ready = (state_reg == ST_IDLE);
    assign in_fire        = particle.valid && particle.ready;
    assign cfg.ready      = 1'b1;

    assign result.valid   = ovalid_reg;
    assign result.force_x = fx_reg;
    assign result.force_y = fy_reg;
    assign result.status  = st_reg;

    // Offsets, magnitudes and the clipping of intermediate terms
    always_comb
    begin
        dx       = {particle.particle_x[31], particle.particle_x}
                 - {particle.sample_x[31], particle.sample_x};
        dy       = {particle.particle_y[31], particle.particle_y}
                 - {particle.sample_y[31], particle.sample_y};
        ndx      = 33'd0 - dx;
        ndy      = 33'd0 - dy;
        err      = {1'b0, dens_reg} - {1'b0, target_reg};
        nerr     = 33'd0 - err;
        err_mag  = err[32] ? nerr[31:0] : err[31:0];
        ngain    = 32'd0 - gain_reg;
        gain_mag = gain_reg[31] ? ngain : gain_reg;
        sq_sum   = {1'b0, qx_reg} + {1'b0, alu_rsp.result[63:0]};
        clip1    = |alu_rsp.result[95:63];
        t1_val   = clip1 ? TERM_CAP : alu_rsp.result[62:16];
        clip3    = |alu_rsp.result[63:47];
        t3_val   = clip3 ? TERM_CAP : alu_rsp.result[46:0];
        addx     = sat_add48(sum_x_reg, tx_reg, pneg_reg ^ xneg_reg);
        addy     = sat_add48(sum_y_reg, alu_rsp.result[76:30], pneg_reg ^ yneg_reg);
        osat_x   = !((&sum_x_reg[47:31]) || !(|sum_x_reg[47:31]));
        osat_y   = !((&sum_y_reg[47:31]) || !(|sum_y_reg[47:31]));
    end

    // Sequencer: steps wait for the shared unit, take its result, start next op or sum up
    always_comb
    begin
        state_next  = state_reg;
        ax_next     = ax_reg;
        ay_next     = ay_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        dens_next   = dens_reg;
        last_next   = last_reg;
        qx_next     = qx_reg;
        dist_next   = dist_reg;
        pmag_next   = pmag_reg;
        pneg_next   = pneg_reg;
        t_next      = t_reg;
        tsat_next   = tsat_reg;
        dirx_next   = dirx_reg;
        diry_next   = diry_reg;
        tx_next     = tx_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sat_next    = sat_reg;
        zden_next   = zden_reg;
        ovalid_next = ovalid_reg && !result.ready;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        st_next     = st_reg;
        alu_req     = '{start: 1'b0, op: OP_MUL, a: '0, b: '0};

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ax_next    = dx[32] ? ndx[31:0] : dx[31:0];
                    ay_next    = dy[32] ? ndy[31:0] : dy[31:0];
                    xneg_next  = dx[32];
                    yneg_next  = dy[32];
                    dens_next  = particle.particle_density;
                    last_next  = particle.last_particle;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // Skip a coincident particle; flag and skip a zero density
                if (ax_reg == '0 && ay_reg == '0)
                    state_next = ST_FIN;
                else if (dens_reg == '0)
                begin
                    zden_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {32'd0, ax_reg}, b: {32'd0, ax_reg}};
                    state_next = ST_SQX;
                end
            end
            ST_SQX:
            begin
                if (alu_rsp.done)
                begin
                    qx_next    = alu_rsp.result[63:0];
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {32'd0, ay_reg}, b: {32'd0, ay_reg}};
                    state_next = ST_SQY;
                end
            end
            ST_SQY:
            begin
                if (alu_rsp.done)
                begin
                    // Squared distance beyond 64 bits lies outside any radius
                    if (sq_sum[64])
                        state_next = ST_FIN;
                    else
                    begin
                        alu_req    = '{start: 1'b1, op: OP_SQRT, a: sq_sum[63:0], b: '0};
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (alu_rsp.done)
                begin
                    dist_next = alu_rsp.result[31:0];
                    if (alu_rsp.result[31:0] >= radius_reg)
                        state_next = ST_FIN;
                    else
                    begin
                        pneg_next  = err[32] ^ gain_reg[31];
                        alu_req    = '{start: 1'b1, op: OP_MUL,
                                       a: {32'd0, err_mag}, b: {32'd0, gain_mag}};
                        state_next = ST_PRS;
                    end
                end
            end
            ST_PRS:
            begin
                if (alu_rsp.done)
                begin
                    pmag_next  = alu_rsp.result[62:16];
                    alu_req    = '{start: 1'b1, op: OP_MUL, a: {16'd0, kscale_reg},
                                   b: {32'd0, radius_reg - dist_reg}};
                    state_next = ST_SLP;
                end
            end
            ST_SLP:
            begin
                if (alu_rsp.done)
                begin
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {16'd0, alu_rsp.result[79:32]},
                                   b: {17'd0, pmag_reg}};
                    state_next = ST_T1;
                end
            end
            ST_T1:
            begin
                if (alu_rsp.done)
                begin
                    t_next     = t1_val;
                    tsat_next  = clip1;
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {17'd0, t1_val}, b: {32'd0, mass_reg}};
                    state_next = ST_T2;
                end
            end
            ST_T2:
            begin
                if (alu_rsp.done)
                begin
                    t_next     = t1_val;
                    tsat_next  = tsat_reg || clip1;
                    alu_req    = '{start: 1'b1, op: OP_DIV,
                                   a: {1'b0, t1_val, 16'd0}, b: {32'd0, dens_reg}};
                    state_next = ST_T3;
                end
            end
            ST_T3:
            begin
                if (alu_rsp.done)
                begin
                    t_next     = t3_val;
                    sat_next   = sat_reg || tsat_reg || clip3;
                    alu_req    = '{start: 1'b1, op: OP_DIV,
                                   a: {2'b00, ax_reg, 30'd0}, b: {32'd0, dist_reg}};
                    state_next = ST_DIRX;
                end
            end
            ST_DIRX:
            begin
                if (alu_rsp.done)
                begin
                    dirx_next  = alu_rsp.result[30:0];
                    alu_req    = '{start: 1'b1, op: OP_DIV,
                                   a: {2'b00, ay_reg, 30'd0}, b: {32'd0, dist_reg}};
                    state_next = ST_DIRY;
                end
            end
            ST_DIRY:
            begin
                if (alu_rsp.done)
                begin
                    diry_next  = alu_rsp.result[30:0];
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {17'd0, t_reg}, b: {33'd0, dirx_reg}};
                    state_next = ST_TX;
                end
            end
            ST_TX:
            begin
                if (alu_rsp.done)
                begin
                    tx_next    = alu_rsp.result[76:30];
                    alu_req    = '{start: 1'b1, op: OP_MUL,
                                   a: {17'd0, t_reg}, b: {33'd0, diry_reg}};
                    state_next = ST_TY;
                end
            end
            ST_TY:
            begin
                if (alu_rsp.done)
                begin
                    sum_x_next = addx[47:0];
                    sum_y_next = addy[47:0];
                    sat_next   = sat_reg || addx[48] || addy[48];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Last word: hold until the output register is free, then emit and clear
                if (!last_reg)
                    state_next = ST_IDLE;
                else if (!ovalid_reg || result.ready)
                begin
                    ovalid_next = 1'b1;
                    fx_next     = osat_x ? (sum_x_reg[47] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                         : sum_x_reg[31:0];
                    fy_next     = osat_y ? (sum_y_reg[47] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                         : sum_y_reg[31:0];
                    st_next     = {zden_reg, sat_reg || osat_x || osat_y};
                    sum_x_next  = '0;
                    sum_y_next  = '0;
                    sat_next    = 1'b0;
                    zden_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RST;
            kscale_reg <= KSCALE_RST;
            target_reg <= TARGET_RST;
            gain_reg   <= GAIN_RST;
            mass_reg   <= MASS_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_RADIUS: radius_reg <= cfg.data[31:0];
                REG_KSCALE: kscale_reg <= cfg.data;
                REG_TARGET: target_reg <= cfg.data[31:0];
                REG_GAIN:   gain_reg   <= cfg.data[31:0];
                REG_MASS:   mass_reg   <= cfg.data[31:0];
                default:    ;
            endcase
        end
    end

    // Control and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sat_reg    <= 1'b0;
            zden_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sat_reg    <= sat_next;
            zden_reg   <= zden_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        xneg_reg <= xneg_next;
        yneg_reg <= yneg_next;
        dens_reg <= dens_next;
        last_reg <= last_next;
        qx_reg   <= qx_next;
        dist_reg <= dist_next;
        pmag_reg <= pmag_next;
        pneg_reg <= pneg_next;
        t_reg    <= t_next;
        tsat_reg <= tsat_next;
        dirx_reg <= dirx_next;
        diry_reg <= diry_next;
        tx_reg   <= tx_next;
        fx_reg   <= fx_next;
        fy_reg   <= fy_next;
        st_reg   <= st_next;
    end

`ifndef SYNTHESIS
    a_idle_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !alu_rsp.busy)
        else $error("shared unit busy while sequencer idle");

    a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
        (particle.valid && particle.ready) |=> (state_reg == ST_CHECK))
        else $error("accepted word did not enter check");

    a_emit_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg == ST_FIN && last_reg))
        else $error("force word loaded outside the last particle");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> !(state_reg == ST_IDLE || state_reg == ST_CHECK
                           || state_reg == ST_FIN))
        else $error("shared unit result with no waiting step");
`endif

endmodule
